/* rtl/ep2cal_pkg.sv */
package ep2cal_pkg;

	localparam int EPOCH_W  = 31;
	localparam int YEAR_W   = 11;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int DAYS_W   = 15;

	localparam int SEC_PER_MIN  = 60;
	localparam int MIN_PER_HOUR = 60;
	localparam int HOUR_PER_DAY = 24;

	localparam int EPOCH_YEAR      = 1970;
	localparam int COMMON_YEAR_LEN = 365;
	localparam int LEAP_YEAR_LEN   = 366;
	localparam int FEB_LEAP_DAYS   = 29;

	localparam int EPOCH_MOD4   = EPOCH_YEAR % 4;
	localparam int EPOCH_MOD100 = EPOCH_YEAR % 100;
	localparam int EPOCH_MOD400 = EPOCH_YEAR % 400;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [DAYS_W-1:0]   days;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} ep2cal_tod_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (idx)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? DAY_W'(FEB_LEAP_DAYS) : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/ep2cal_if.sv */
interface ep2cal_in_if;
	import ep2cal_pkg::*;

	logic                valid;
	logic                ready;
	logic [EPOCH_W-1:0]  epoch_seconds;

	modport source(output valid, output epoch_seconds, input ready);
	modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface ep2cal_out_if;
	import ep2cal_pkg::*;

	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day_of_month;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;

	modport source(output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, input ready);
	modport sink(input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, output ready);
endinterface

/* rtl/epoch_seconds_to_calendar.sv */
// the front turns each request into a day count and time of day (a multiply and a
// remainder step for each of 60, 60 and 24, then the hand-off), and the back walks
// one step per year (up to 68) and one per month (up to 11) to reach the date
// the back takes a new day count only when idle, after its year and month walk;
// the front runs ahead behind a two-entry queue
// reset: arst_n clears all control state and the queue; payload registers keep their contents
module epoch_seconds_to_calendar #(
	parameter int QueueDepth = ep2cal_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	ep2cal_in_if.sink     in_ch,
	ep2cal_out_if.source  out_ch
);
	import ep2cal_pkg::*;

	ep2cal_tod_t front_tod;
	logic        front_valid;
	logic        front_ready;
	ep2cal_tod_t back_tod;
	logic        back_valid;
	logic        back_ready;

	ep2cal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (in_ch),
		.tod       (front_tod),
		.tod_valid (front_valid),
		.tod_ready (front_ready)
	);

	ep2cal_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_tod),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_tod)
	);

	ep2cal_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tod       (back_tod),
		.tod_valid (back_valid),
		.tod_ready (back_ready),
		.res       (out_ch)
	);

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("front took a request while dividing");

	a_out_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.month >= 4'd1 && out_ch.month <= 4'd12 &&
			out_ch.day_of_month != '0 && out_ch.hour < 5'd24 &&
			out_ch.minute < 6'd60 && out_ch.second < 6'd60))
		else $error("result field out of range");

	a_out_year: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.year >= YEAR_W'(EPOCH_YEAR))
		else $error("year below epoch");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(back_valid && back_ready) |=> !back_ready)
		else $error("back took a day count while busy");

endmodule

/* rtl/ep2cal_front.sv */
module ep2cal_front (
	input  logic                    clk,
	input  logic                    arst_n,
	ep2cal_in_if.sink               req,
	output ep2cal_pkg::ep2cal_tod_t tod,
	output logic                    tod_valid,
	input  logic                    tod_ready
);
	import ep2cal_pkg::*;

	localparam int REM_W  = 6;
	localparam int PROD_W = 63;
	localparam int SH_60  = 37;
	localparam int SH_24  = 36;

	// ceil(2^37 / 60) and ceil(2^36 / 24), exact for any 31-bit dividend
	localparam logic [31:0] RECIP_60 = 32'd2290649225;
	localparam logic [31:0] RECIP_24 = 32'd2863311531;

	typedef enum logic [2:0] {S_IDLE, S_SEC_Q, S_SEC_R, S_MIN_Q, S_MIN_R,
		S_HR_Q, S_HR_R, S_PUSH} state_t;

	state_t                state_q;
	logic [EPOCH_W-1:0]    dvd_q;
	logic [EPOCH_W-1:0]    quo_q;
	logic [SECOND_W-1:0]   sec_q;
	logic [MINUTE_W-1:0]   min_q;
	logic [HOUR_W-1:0]     hr_q;

	logic                  hr_stage;
	logic [REM_W-1:0]      divisor;
	logic [31:0]           recip;
	logic [PROD_W-1:0]     prod;
	logic [EPOCH_W-1:0]    quo;
	logic [REM_W-1:0]      rem;
	logic                  accept;

	always_comb begin
		case (state_q)
			S_MIN_Q, S_MIN_R: divisor = REM_W'(MIN_PER_HOUR);
			S_HR_Q, S_HR_R:   divisor = REM_W'(HOUR_PER_DAY);
			default:          divisor = REM_W'(SEC_PER_MIN);
		endcase
	end

	assign hr_stage  = (state_q == S_HR_Q) || (state_q == S_HR_R);
	assign recip     = hr_stage ? RECIP_24 : RECIP_60;
	assign prod      = PROD_W'(dvd_q) * PROD_W'(recip);
	assign quo       = hr_stage ? EPOCH_W'(prod >> SH_24) : EPOCH_W'(prod >> SH_60);
	assign rem       = dvd_q[REM_W-1:0] - REM_W'(quo_q * EPOCH_W'(divisor));
	assign req.ready = state_q == S_IDLE;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (req.valid) state_q <= S_SEC_Q;
				S_SEC_Q: state_q <= S_SEC_R;
				S_SEC_R: state_q <= S_MIN_Q;
				S_MIN_Q: state_q <= S_MIN_R;
				S_MIN_R: state_q <= S_HR_Q;
				S_HR_Q:  state_q <= S_HR_R;
				S_HR_R:  state_q <= S_PUSH;
				S_PUSH: begin
					if (tod_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// quotient cycle, then remainder cycle that hands the quotient on
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) dvd_q <= req.epoch_seconds;
			end
			S_SEC_Q, S_MIN_Q, S_HR_Q: quo_q <= quo;
			S_SEC_R: begin
				sec_q <= rem;
				dvd_q <= quo_q;
			end
			S_MIN_R: begin
				min_q <= rem;
				dvd_q <= quo_q;
			end
			S_HR_R: begin
				hr_q  <= rem[HOUR_W-1:0];
				dvd_q <= quo_q;
			end
			default: ;
		endcase
	end

	assign tod_valid  = state_q == S_PUSH;
	assign tod.days   = dvd_q[DAYS_W-1:0];
	assign tod.hour   = hr_q;
	assign tod.minute = min_q;
	assign tod.second = sec_q;

endmodule

/* rtl/ep2cal_queue.sv */
module ep2cal_queue #(
	parameter int Depth = ep2cal_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  ep2cal_pkg::ep2cal_tod_t push_data,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output ep2cal_pkg::ep2cal_tod_t pop_data
);
	import ep2cal_pkg::*;

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	ep2cal_tod_t        entry_q [Depth];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = cnt_q != CNT_W'(Depth);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/ep2cal_back.sv */
module ep2cal_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ep2cal_pkg::ep2cal_tod_t tod,
	input  logic                    tod_valid,
	output logic                    tod_ready,
	ep2cal_out_if.source            res
);
	import ep2cal_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_YEAR, S_MONTH, S_DONE} state_t;

	state_t               state_q;
	logic                 out_valid_q;

	logic [DAYS_W-1:0]    days_q;
	logic [YEAR_W-1:0]    year_q;
	logic [1:0]           y4_q;
	logic [6:0]           y100_q;
	logic [8:0]           y400_q;
	logic [MONTH_W-1:0]   mon_q;
	ep2cal_tod_t          tod_q;

	logic [YEAR_W-1:0]    out_year_q;
	logic [MONTH_W-1:0]   out_month_q;
	logic [DAY_W-1:0]     out_day_q;
	logic [HOUR_W-1:0]    out_hour_q;
	logic [MINUTE_W-1:0]  out_minute_q;
	logic [SECOND_W-1:0]  out_second_q;

	logic                 leap;
	logic [DAYS_W-1:0]    ylen;
	logic [DAYS_W-1:0]    mlen;
	logic                 year_fits;
	logic                 month_fits;
	logic                 load;

	assign leap       = ((y4_q == '0) && (y100_q != '0)) || (y400_q == '0);
	assign ylen       = leap ? DAYS_W'(LEAP_YEAR_LEN) : DAYS_W'(COMMON_YEAR_LEN);
	assign mlen       = DAYS_W'(month_len(mon_q, leap));
	assign year_fits  = days_q < ylen;
	assign month_fits = days_q < mlen;
	assign tod_ready  = state_q == S_IDLE;
	assign load       = (state_q == S_DONE) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (tod_valid) state_q <= S_YEAR;
				S_YEAR:  if (year_fits) state_q <= S_MONTH;
				S_MONTH: if (month_fits) state_q <= S_DONE;
				S_DONE: begin
					if (load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (tod_valid) begin
					days_q <= tod.days;
					tod_q  <= tod;
					year_q <= YEAR_W'(EPOCH_YEAR);
					y4_q   <= 2'(EPOCH_MOD4);
					y100_q <= 7'(EPOCH_MOD100);
					y400_q <= 9'(EPOCH_MOD400);
					mon_q  <= '0;
				end
			end
			S_YEAR: begin
				if (!year_fits) begin
					days_q <= days_q - ylen;
					year_q <= year_q + 1'b1;
					y4_q   <= y4_q + 1'b1;
					y100_q <= (y100_q == 7'd99) ? '0 : y100_q + 1'b1;
					y400_q <= (y400_q == 9'd399) ? '0 : y400_q + 1'b1;
				end
			end
			S_MONTH: begin
				if (!month_fits) begin
					days_q <= days_q - mlen;
					mon_q  <= mon_q + 1'b1;
				end
			end
			S_DONE: begin
				if (load) begin
					out_year_q   <= year_q;
					out_month_q  <= mon_q + 1'b1;
					out_day_q    <= days_q[DAY_W-1:0] + 1'b1;
					out_hour_q   <= tod_q.hour;
					out_minute_q <= tod_q.minute;
					out_second_q <= tod_q.second;
				end
			end
			default: ;
		endcase
	end

	assign res.valid        = out_valid_q;
	assign res.year         = out_year_q;
	assign res.month        = out_month_q;
	assign res.day_of_month = out_day_q;
	assign res.hour         = out_hour_q;
	assign res.minute       = out_minute_q;
	assign res.second       = out_second_q;

endmodule
